FILE: hdl/bfha_pkg.sv
// shared types and constants for the best-fit heap allocator
package bfha_pkg;

	// operation codes carried on the input tuser
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOFIT   = 3'd1;
	localparam logic [2:0] ST_NULL    = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	// block header and the smallest remainder worth keeping as an extent
	localparam logic [31:0] HDR_BYTES = 32'd8;
	localparam logic [23:0] MIN_SPARE = 24'd44;

	// pool register values after reset
	localparam logic [31:0] RESET_BASE  = 32'd0;
	localparam logic [23:0] RESET_BYTES = 24'd65536;

endpackage

FILE: hdl/bfha_ext_mem.sv
// free extent table: start and size per entry, one write and one registered read port
module bfha_ext_mem import bfha_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wstart,
	input  logic [23:0]              wsize,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	input  logic                     ent0_rst,
	output logic [31:0]              rstart,
	output logic [23:0]              rsize
);

	logic [31:0] start_mem [DEPTH];
	logic [23:0] size_mem  [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			start_mem[waddr] <= wstart;
			size_mem[waddr]  <= wsize;
		end
	end

	// read port, entry zero shows the reset extent until first written
	always_ff @(posedge clk) begin
		if (ent0_rst && raddr == '0) begin
			rstart <= RESET_BASE;
			rsize  <= RESET_BYTES;
		end else begin
			rstart <= start_mem[raddr];
			rsize  <= size_mem[raddr];
		end
	end

endmodule

FILE: hdl/bfha_blk_mem.sv
// allocation table: user address, block start and length per slot
module bfha_blk_mem #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wuser,
	input  logic [31:0]              wstart,
	input  logic [23:0]              wlen,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]              ruser,
	output logic [31:0]              rstart,
	output logic [23:0]              rlen
);

	logic [31:0] user_mem  [DEPTH];
	logic [31:0] start_mem [DEPTH];
	logic [23:0] len_mem   [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			user_mem[waddr]  <= wuser;
			start_mem[waddr] <= wstart;
			len_mem[waddr]   <= wlen;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		ruser  <= user_mem[raddr];
		rstart <= start_mem[raddr];
		rlen   <= len_mem[raddr];
	end

endmodule

FILE: hdl/best_fit_heap_allocator_core.sv
// best-fit heap allocator with address-ordered, coalescing free extent table
//
// One command word enters on the s_ channel (opcode in s_tuser) and exactly one
// result word leaves on the m_ channel (status in m_tuser). Commands are
// allocate, release and restart. s_tready is high only while the sequencer is
// idle; a command then runs to completion before the next one is taken.
// Allocate: one pass over the n free extents (one entry a cycle) while the
// first free slot of the allocation table is searched alongside, then an
// optional removal of the chosen extent, each moved entry read and then
// written one place over.
// Release: a search of the allocation table, one slot a cycle, a pass to the
// insert point, then a merge or an insertion moving up to n entries, each
// read and then written one place over.
// Each table has a single read port.
// Reset gives one free extent (base 0, 65536 bytes), no blocks and no bytes in
// use; pool_base and pool_bytes written later take effect at a restart.
// A finished result waits in the output register while m_tready is low; a new
// command can be taken meanwhile, and its result is held back until the
// previous word is taken.
module best_fit_heap_allocator_core import bfha_pkg::*; #(
	parameter int MAX_EXTENTS = 32,
	parameter int MAX_BLOCKS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: request_bytes[23:0], pad_bytes[39:24], user_address[71:40]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,
	// s_tuser: opcode[1:0]
	input  logic [1:0]  s_tuser,
	// m_tdata: granted_address[31:0], granted_bytes[55:32], bytes_in_use[79:56],
	//          free_extent_count[85:80], zero fill[87:86]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,
	// m_tuser: status[2:0]
	output logic [2:0]  m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_wdata
);

	localparam int EW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int BW = $clog2(MAX_BLOCKS);
	localparam logic [CW-1:0] EXT_N    = CW'(MAX_EXTENTS);
	localparam logic [BW:0]   BLK_N    = (BW+1)'(MAX_BLOCKS);
	localparam logic [BW-1:0] BLK_LAST = BW'(MAX_BLOCKS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_A_SCAN, S_A_SLOT, S_A_CARVE, S_MV_RD, S_MV_WR, S_BLK_WR,
		S_R_SRCH, S_R_POS, S_R_MERGE, S_R_INS, S_R_FIN, S_DONE
	} state_t;

	state_t state_q, ret_q;

	logic [31:0] pool_base_q;
	logic [23:0] pool_bytes_q;

	logic [CW-1:0]   cnt_q, sc_q, p_q, mv_i_q;
	logic [23:0]     in_use_q;
	logic [MAX_BLOCKS-1:0] blk_valid_q;
	logic            ent0_rst_q;
	logic [31:0]     ua_q;
	logic [24:0]     need_q;
	logic [16:0]     padr_q;
	logic            vld_s1;
	logic [EW-1:0]   idx_s1;
	logic            found_q, exact_q;
	logic [EW-1:0]   best_q;
	logic [31:0]     best_start_q;
	logic [23:0]     best_size_q;
	logic [BW-1:0]   slot_q;
	logic            slot_done_q, slot_hit_q;
	logic [31:0]     bs_q;
	logic [23:0]     bl_q;
	logic [BW-1:0]   b_q;
	logic [BW:0]     bj_q;
	logic            bvld_s1;
	logic [BW-1:0]   bidx_s1;
	logic [31:0]     prev_start_q, next_start_q;
	logic [23:0]     prev_size_q, next_size_q;
	logic            mv_up_q, del_q;
	logic [2:0]      res_status_q;
	logic [31:0]     res_addr_q;
	logic [23:0]     res_len_q;
	logic            m_tvalid_q;
	logic [87:0]     m_tdata_q;
	logic [2:0]      m_tuser_q;

	logic          ext_we;
	logic [EW-1:0] ext_waddr, ext_raddr;
	logic [31:0]   ext_wstart, ext_rstart;
	logic [23:0]   ext_wsize, ext_rsize;
	logic          blk_we;
	logic [BW-1:0] blk_raddr;
	logic [31:0]   blk_ruser, blk_rstart;
	logic [23:0]   blk_rlen;

	logic [23:0] in_req, req_nz;
	logic [15:0] in_pad;
	logic [31:0] in_ua;
	logic [24:0] req_r;
	logic [16:0] pad_r;
	logic [24:0] need_new;
	logic [23:0] spare;
	logic        spare_small;
	logic        mprev, mnext;
	logic [31:0] blk_ua_new;
	logic [CW-1:0] mv_src;
	logic        mv_go;

	assign in_req = s_tdata[23:0];
	assign in_pad = s_tdata[39:24];
	assign in_ua  = s_tdata[71:40];

	// request size: rounded to words, zero as one, plus header and rounded pad
	assign req_nz   = (in_req == 24'd0) ? 24'd1 : in_req;
	assign req_r    = ({1'b0, req_nz} + 25'd3) & ~25'd3;
	assign pad_r    = ({1'b0, in_pad} + 17'd3) & ~17'd3;
	assign need_new = req_r + HDR_BYTES[24:0] + {8'd0, pad_r};

	// carve decision and new block address
	assign spare       = best_size_q - need_q[23:0];
	assign spare_small = spare < MIN_SPARE;
	assign blk_ua_new  = bs_q + HDR_BYTES + {15'd0, padr_q};

	// neighbour contact on release
	assign mnext = (p_q < cnt_q) && ((bs_q + {8'd0, bl_q}) == next_start_q);
	assign mprev = (p_q != '0) && ((prev_start_q + {8'd0, prev_size_q}) == bs_q);

	// entry mover source and loop test
	assign mv_src = mv_up_q ? (mv_i_q - 1'b1) : (mv_i_q + 1'b1);
	assign mv_go  = mv_up_q ? (mv_i_q > p_q)
	                        : (({1'b0, mv_i_q} + 1'b1) < {1'b0, cnt_q});

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	bfha_ext_mem #(.DEPTH(MAX_EXTENTS)) u_ext (
		.clk      (clk),
		.we       (ext_we),
		.waddr    (ext_waddr),
		.wstart   (ext_wstart),
		.wsize    (ext_wsize),
		.raddr    (ext_raddr),
		.ent0_rst (ent0_rst_q),
		.rstart   (ext_rstart),
		.rsize    (ext_rsize)
	);

	bfha_blk_mem #(.DEPTH(MAX_BLOCKS)) u_blk (
		.clk    (clk),
		.we     (blk_we),
		.waddr  (slot_q),
		.wuser  (blk_ua_new),
		.wstart (bs_q),
		.wlen   (bl_q),
		.raddr  (blk_raddr),
		.ruser  (blk_ruser),
		.rstart (blk_rstart),
		.rlen   (blk_rlen)
	);

	// table port steering per sequencer step
	always_comb begin
		ext_we     = 1'b0;
		ext_waddr  = '0;
		ext_wstart = '0;
		ext_wsize  = '0;
		ext_raddr  = '0;
		blk_we     = 1'b0;
		blk_raddr  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tuser == OP_RESTART) begin
					ext_we     = 1'b1;
					ext_wstart = pool_base_q & ~32'd3;
					ext_wsize  = pool_bytes_q & ~24'd3;
				end
			end
			S_A_SCAN, S_R_POS: begin
				ext_raddr = sc_q[EW-1:0];
			end
			S_A_CARVE: begin
				if (!spare_small) begin
					ext_we     = 1'b1;
					ext_waddr  = best_q;
					ext_wstart = best_start_q;
					ext_wsize  = spare;
				end
			end
			S_MV_RD: begin
				ext_raddr = mv_src[EW-1:0];
			end
			S_MV_WR: begin
				ext_we     = 1'b1;
				ext_waddr  = mv_i_q[EW-1:0];
				ext_wstart = ext_rstart;
				ext_wsize  = ext_rsize;
			end
			S_R_MERGE: begin
				if (mprev) begin
					ext_we     = 1'b1;
					ext_waddr  = EW'(p_q - 1'b1);
					ext_wstart = prev_start_q;
					ext_wsize  = mnext ? (prev_size_q + bl_q + next_size_q)
					                   : (prev_size_q + bl_q);
				end else if (mnext) begin
					ext_we     = 1'b1;
					ext_waddr  = p_q[EW-1:0];
					ext_wstart = bs_q;
					ext_wsize  = next_size_q + bl_q;
				end
			end
			S_R_INS: begin
				ext_we     = 1'b1;
				ext_waddr  = p_q[EW-1:0];
				ext_wstart = bs_q;
				ext_wsize  = bl_q;
			end
			S_R_SRCH: begin
				blk_raddr = bj_q[BW-1:0];
			end
			S_BLK_WR: begin
				blk_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// pool registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= RESET_BASE;
			pool_bytes_q <= RESET_BYTES;
		end else if (cfg_we) begin
			if (cfg_addr == 1'b0) pool_base_q  <= cfg_wdata;
			else                  pool_bytes_q <= cfg_wdata[23:0];
		end
	end

	// sequencer, table state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cnt_q       <= CW'(1);
			in_use_q    <= '0;
			blk_valid_q <= '0;
			ent0_rst_q  <= 1'b1;
			m_tvalid_q  <= 1'b0;
			vld_s1      <= 1'b0;
			bvld_s1     <= 1'b0;
			slot_done_q <= 1'b0;
			slot_hit_q  <= 1'b0;
			found_q     <= 1'b0;
			exact_q     <= 1'b0;
			del_q       <= 1'b0;
			mv_up_q     <= 1'b0;
		end else begin
			// entry zero holds real data once written
			if (ext_we && ext_waddr == '0) ent0_rst_q <= 1'b0;
			// word taken while no new result is loaded
			if (m_tvalid_q && m_tready && state_q != S_DONE) m_tvalid_q <= 1'b0;

			// free slot search runs beside the extent pass
			if ((state_q == S_A_SCAN || state_q == S_A_SLOT) && !slot_done_q) begin
				if (!blk_valid_q[slot_q]) begin
					slot_hit_q  <= 1'b1;
					slot_done_q <= 1'b1;
				end else if (slot_q == BLK_LAST) begin
					slot_done_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						res_status_q <= ST_OK;
						res_addr_q   <= '0;
						res_len_q    <= '0;
						del_q        <= 1'b0;
						unique case (s_tuser)
							OP_ALLOC: begin
								need_q      <= need_new;
								padr_q      <= pad_r;
								sc_q        <= '0;
								vld_s1      <= 1'b0;
								found_q     <= 1'b0;
								exact_q     <= 1'b0;
								slot_q      <= '0;
								slot_done_q <= 1'b0;
								slot_hit_q  <= 1'b0;
								state_q     <= S_A_SCAN;
							end
							OP_RELEASE: begin
								if (in_ua == 32'd0) begin
									res_status_q <= ST_NULL;
									state_q      <= S_DONE;
								end else begin
									ua_q    <= in_ua;
									bj_q    <= '0;
									bvld_s1 <= 1'b0;
									state_q <= S_R_SRCH;
								end
							end
							OP_RESTART: begin
								cnt_q       <= CW'(1);
								blk_valid_q <= '0;
								in_use_q    <= '0;
								state_q     <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end

				// best-fit pass over the extents, one read a cycle
				S_A_SCAN: begin
					if (sc_q < cnt_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= sc_q[EW-1:0];
						sc_q   <= sc_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						if ({1'b0, ext_rsize} == need_q) begin
							if (!exact_q) begin
								exact_q      <= 1'b1;
								found_q      <= 1'b1;
								best_q       <= idx_s1;
								best_start_q <= ext_rstart;
								best_size_q  <= ext_rsize;
							end
						end else if (({1'b0, ext_rsize} > need_q) && !exact_q &&
						             (!found_q || ext_rsize < best_size_q)) begin
							found_q      <= 1'b1;
							best_q       <= idx_s1;
							best_start_q <= ext_rstart;
							best_size_q  <= ext_rsize;
						end
					end else if (sc_q >= cnt_q) begin
						if (!found_q) begin
							res_status_q <= ST_NOFIT;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_A_SLOT;
						end
					end
				end

				S_A_SLOT: begin
					if (slot_done_q) begin
						if (slot_hit_q) begin
							state_q <= S_A_CARVE;
						end else begin
							res_status_q <= ST_FULL;
							state_q      <= S_DONE;
						end
					end
				end

				// hand over the whole extent or carve from its top
				S_A_CARVE: begin
					if (spare_small) begin
						bs_q    <= best_start_q;
						bl_q    <= best_size_q;
						del_q   <= 1'b1;
						mv_i_q  <= CW'(best_q);
						mv_up_q <= 1'b0;
						ret_q   <= S_BLK_WR;
						state_q <= S_MV_RD;
					end else begin
						bs_q    <= best_start_q + {8'd0, spare};
						bl_q    <= need_q[23:0];
						state_q <= S_BLK_WR;
					end
				end

				// entry mover: read neighbour, then write it one place over
				S_MV_RD: begin
					state_q <= mv_go ? S_MV_WR : ret_q;
				end

				S_MV_WR: begin
					mv_i_q  <= mv_up_q ? (mv_i_q - 1'b1) : (mv_i_q + 1'b1);
					state_q <= S_MV_RD;
				end

				S_BLK_WR: begin
					blk_valid_q[slot_q] <= 1'b1;
					in_use_q            <= in_use_q + bl_q;
					if (del_q) cnt_q <= cnt_q - 1'b1;
					res_addr_q <= blk_ua_new;
					res_len_q  <= bl_q;
					state_q    <= S_DONE;
				end

				// allocation table lookup, lowest matching slot wins
				S_R_SRCH: begin
					if (bj_q < BLK_N) begin
						bvld_s1 <= 1'b1;
						bidx_s1 <= bj_q[BW-1:0];
						bj_q    <= bj_q + 1'b1;
					end else begin
						bvld_s1 <= 1'b0;
					end
					if (bvld_s1 && blk_valid_q[bidx_s1] && blk_ruser == ua_q) begin
						bs_q    <= blk_rstart;
						bl_q    <= blk_rlen;
						b_q     <= bidx_s1;
						sc_q    <= '0;
						vld_s1  <= 1'b0;
						state_q <= S_R_POS;
					end else if (!bvld_s1 && bj_q == BLK_N) begin
						res_status_q <= ST_UNKNOWN;
						state_q      <= S_DONE;
					end
				end

				// find the first extent not below the block start
				S_R_POS: begin
					if (sc_q < cnt_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= sc_q[EW-1:0];
						sc_q   <= sc_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						if (ext_rstart < bs_q) begin
							prev_start_q <= ext_rstart;
							prev_size_q  <= ext_rsize;
						end else begin
							p_q          <= CW'(idx_s1);
							next_start_q <= ext_rstart;
							next_size_q  <= ext_rsize;
							state_q      <= S_R_MERGE;
						end
					end else if (sc_q >= cnt_q) begin
						p_q     <= cnt_q;
						state_q <= S_R_MERGE;
					end
				end

				// merge with neighbours or open a gap for a new extent
				S_R_MERGE: begin
					if (mprev && mnext) begin
						del_q   <= 1'b1;
						mv_i_q  <= p_q;
						mv_up_q <= 1'b0;
						ret_q   <= S_R_FIN;
						state_q <= S_MV_RD;
					end else if (mprev || mnext) begin
						state_q <= S_R_FIN;
					end else if (cnt_q >= EXT_N) begin
						res_status_q <= ST_FULL;
						state_q      <= S_DONE;
					end else begin
						mv_i_q  <= cnt_q;
						mv_up_q <= 1'b1;
						ret_q   <= S_R_INS;
						state_q <= S_MV_RD;
					end
				end

				S_R_INS: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_R_FIN;
				end

				S_R_FIN: begin
					blk_valid_q[b_q] <= 1'b0;
					in_use_q         <= in_use_q - bl_q;
					if (del_q) cnt_q <= cnt_q - 1'b1;
					res_len_q <= bl_q;
					state_q   <= S_DONE;
				end

				// hand the result word to the output register
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= res_status_q;
						m_tdata_q  <= {2'd0, 6'(cnt_q), in_use_q, res_len_q, res_addr_q};
						state_q    <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
